// ===== src/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg
// Shared constants, codes and interface types for the spherical polygon
// area unit.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int unsigned SineSteps = 24;
  localparam int unsigned StepW = $clog2(SineSteps);

  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] Deg7RadFull = PiQ60 / 64'd1800000000;
  localparam logic [30:0] Deg7RadQ60 = Deg7RadFull[30:0];

  localparam logic signed [33:0] CordicStart = 34'sd652032874;
  localparam logic signed [30:0] LatLimit = 31'sd900000000;
  localparam logic [22:0] RadiusReset = 23'd6378137;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_LAT,
    MUL_DLON,
    MUL_RAD_LO,
    MUL_RAD_HI,
    MUL_RSQ,
    MUL_MLL,
    MUL_MLH,
    MUL_MHL,
    MUL_MHH
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD32,
    ACC_ADD64
  } acc_op_e;

  typedef struct packed {
    logic             capture;
    mul_sel_e         mul_sel;
    acc_op_e          acc_op;
    logic             rot_init;
    logic             rot_step;
    logic [StepW-1:0] step;
    logic             sine_load;
    logic             closing;
    logic             rad_load;
    logic             edge_add;
    logic             area_prep;
    logic             commit;
    logic             clear_ring;
    logic             out_load;
    logic             out_few;
  } dp_cmd_t;

  typedef struct packed {
    logic has_prev;
    logic too_few;
  } dp_sts_t;

  function automatic logic [29:0] atan_q30(input logic [StepW-1:0] idx);
    logic [29:0] val;
    case (idx)
      StepW'(0): val = 30'd843314857;
      StepW'(1): val = 30'd497837829;
      StepW'(2): val = 30'd263043837;
      StepW'(3): val = 30'd133525159;
      StepW'(4): val = 30'd67021687;
      StepW'(5): val = 30'd33543516;
      StepW'(6): val = 30'd16775851;
      StepW'(7): val = 30'd8388437;
      StepW'(8): val = 30'd4194283;
      StepW'(9): val = 30'd2097149;
      default: begin
        if (32'(idx) <= 32'd30) begin
          val = 30'(32'd1 << (32'd30 - 32'(idx)));
        end else begin
          val = '0;
        end
      end
    endcase
    return val;
  endfunction

endpackage

// ===== src/spa_datapath.sv =====
// ----------------------------------------------------------------------------
// spa_datapath
// Vertex registers, CORDIC sine, shared multiplier with product register,
// wide accumulator, ring state and the result register.
// ----------------------------------------------------------------------------
module spa_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [62:0]      vert_data_i,
  input  logic             cfg_wr_en_i,
  input  logic [22:0]      cfg_wr_data_i,
  input  spa_pkg::dp_cmd_t cmd_i,
  output spa_pkg::dp_sts_t sts_o,
  output logic [48:0]      area_o,
  output logic             few_o,
  output logic             sat_o
);
  import spa_pkg::*;

  logic [22:0]        radius_q;
  logic signed [30:0] lat_q;
  logic signed [31:0] lon_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic signed [31:0] sin_q;
  logic signed [31:0] first_sin_q, prev_sin_q;
  logic signed [31:0] first_lon_q, prev_lon_q;
  logic [63:0]        edge_sum_q;
  logic [1:0]         count_q;
  logic [65:0]        prod_q;
  logic [109:0]       acc_q, acc_d;
  logic [50:0]        rad_q;
  logic [45:0]        rsq_q;
  logic [63:0]        mag_q;
  logic [48:0]        area_q;
  logic               few_q, sat_q;

  logic signed [30:0] lat_c, lat_abs;
  logic [29:0]        lat_mag;
  logic [30:0]        z_mag;
  logic signed [31:0] lon_a, lon_b, sin_other;
  logic signed [32:0] dlon, dlon_abs;
  logic               dneg;
  logic signed [33:0] f2_wide;
  logic [32:0]        f2;
  logic [32:0]        mul_a, mul_b;
  logic [65:0]        prod_d;
  logic signed [33:0] dx, dy, at;
  logic [63:0]        term;

  always_comb begin
    if (lat_q > LatLimit) begin
      lat_c = LatLimit;
    end else if (lat_q < -LatLimit) begin
      lat_c = -LatLimit;
    end else begin
      lat_c = lat_q;
    end
    lat_abs = lat_c[30] ? -lat_c : lat_c;
    lat_mag = lat_abs[29:0];
    z_mag   = prod_q[60:30];
  end

  always_comb begin
    lon_a     = cmd_i.closing ? lon_q : prev_lon_q;
    lon_b     = cmd_i.closing ? first_lon_q : lon_q;
    sin_other = cmd_i.closing ? first_sin_q : prev_sin_q;
    dlon      = {lon_b[31], lon_b} - {lon_a[31], lon_a};
    dneg      = dlon[32];
    dlon_abs  = dneg ? -dlon : dlon;
    f2_wide   = 34'sh080000000 + 34'(sin_q) + 34'(sin_other);
    f2        = f2_wide[32:0];
    term      = {10'd0, acc_q[83:30]};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      MUL_LAT: begin
        mul_a = {3'd0, lat_mag};
        mul_b = {2'd0, Deg7RadQ60};
      end
      MUL_DLON: begin
        mul_a = {1'b0, dlon_abs[31:0]};
        mul_b = {2'd0, Deg7RadQ60};
      end
      MUL_RAD_LO: begin
        mul_a = {1'b0, rad_q[31:0]};
        mul_b = f2;
      end
      MUL_RAD_HI: begin
        mul_a = {14'd0, rad_q[50:32]};
        mul_b = f2;
      end
      MUL_RSQ: begin
        mul_a = {10'd0, radius_q};
        mul_b = {10'd0, radius_q};
      end
      MUL_MLL: begin
        mul_a = {1'b0, mag_q[31:0]};
        mul_b = {1'b0, rsq_q[31:0]};
      end
      MUL_MLH: begin
        mul_a = {1'b0, mag_q[31:0]};
        mul_b = {19'd0, rsq_q[45:32]};
      end
      MUL_MHL: begin
        mul_a = {1'b0, mag_q[63:32]};
        mul_b = {1'b0, rsq_q[31:0]};
      end
      MUL_MHH: begin
        mul_a = {1'b0, mag_q[63:32]};
        mul_b = {19'd0, rsq_q[45:32]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    unique case (cmd_i.acc_op)
      ACC_HOLD:  acc_d = acc_q;
      ACC_LOAD:  acc_d = {44'd0, prod_q};
      ACC_ADD32: acc_d = acc_q + {12'd0, prod_q, 32'd0};
      ACC_ADD64: acc_d = acc_q + {prod_q[45:0], 64'd0};
      default:   acc_d = acc_q;
    endcase
  end

  always_comb begin
    dx = y_q >>> cmd_i.step;
    dy = x_q >>> cmd_i.step;
    at = {4'd0, atan_q30(cmd_i.step)};
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (cmd_i.capture) begin
      lat_q <= vert_data_i[30:0];
      lon_q <= vert_data_i[62:31];
    end
    if (cmd_i.rot_init) begin
      x_q <= CordicStart;
      y_q <= '0;
      z_q <= lat_q[30] ? -$signed({3'd0, z_mag}) : $signed({3'd0, z_mag});
    end else if (cmd_i.rot_step) begin
      if (!z_q[33]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
    if (cmd_i.sine_load) begin
      if (y_q > 34'sh040000000) begin
        sin_q <= 32'sh40000000;
      end else if (y_q < -34'sh040000000) begin
        sin_q <= -32'sh40000000;
      end else begin
        sin_q <= y_q[31:0];
      end
    end
    if (cmd_i.rad_load) begin
      rad_q <= prod_q[62:12];
    end
    if (cmd_i.area_prep) begin
      rsq_q <= prod_q[45:0];
      mag_q <= edge_sum_q[63] ? (64'd0 - edge_sum_q) : edge_sum_q;
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_few) begin
        area_q <= '0;
        few_q  <= 1'b1;
        sat_q  <= 1'b0;
      end else begin
        few_q  <= 1'b0;
        sat_q  <= |acc_q[109:98];
        area_q <= (|acc_q[109:98]) ? '1 : acc_q[97:49];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RadiusReset;
      first_sin_q <= '0;
      first_lon_q <= '0;
      prev_sin_q  <= '0;
      prev_lon_q  <= '0;
      edge_sum_q  <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        radius_q <= cfg_wr_data_i;
      end
      if (cmd_i.clear_ring) begin
        first_sin_q <= '0;
        first_lon_q <= '0;
        prev_sin_q  <= '0;
        prev_lon_q  <= '0;
        edge_sum_q  <= '0;
        count_q     <= '0;
      end else begin
        if (cmd_i.edge_add) begin
          edge_sum_q <= edge_sum_q + (dneg ? (64'd0 - term) : term);
        end
        if (cmd_i.commit) begin
          if (count_q == 2'd0) begin
            first_sin_q <= sin_q;
            first_lon_q <= lon_q;
          end
          prev_sin_q <= sin_q;
          prev_lon_q <= lon_q;
          if (count_q != 2'd3) begin
            count_q <= count_q + 2'd1;
          end
        end
      end
    end
  end

  assign sts_o.has_prev = (count_q != 2'd0);
  assign sts_o.too_few  = (count_q < 2'd2);
  assign area_o = area_q;
  assign few_o  = few_q;
  assign sat_o  = sat_q;

endmodule

// ===== src/spa_ctrl.sv =====
// ----------------------------------------------------------------------------
// spa_ctrl
// Sequencer for one vertex: sine, edge term, closing edge, area scaling and
// the output handshake.
// ----------------------------------------------------------------------------
module spa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic             s_last_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  spa_pkg::dp_sts_t sts_i,
  output spa_pkg::dp_cmd_t cmd_o
);
  import spa_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LAT    = 5'd1;
  localparam logic [4:0] S_ZINIT  = 5'd2;
  localparam logic [4:0] S_ROT    = 5'd3;
  localparam logic [4:0] S_SINE   = 5'd4;
  localparam logic [4:0] S_EMUL   = 5'd5;
  localparam logic [4:0] S_ERAD   = 5'd6;
  localparam logic [4:0] S_EMLO   = 5'd7;
  localparam logic [4:0] S_EMHI   = 5'd8;
  localparam logic [4:0] S_EACC   = 5'd9;
  localparam logic [4:0] S_ESUM   = 5'd10;
  localparam logic [4:0] S_COMMIT = 5'd11;
  localparam logic [4:0] S_RMUL   = 5'd12;
  localparam logic [4:0] S_RCAP   = 5'd13;
  localparam logic [4:0] S_AM0    = 5'd14;
  localparam logic [4:0] S_AM1    = 5'd15;
  localparam logic [4:0] S_AM2    = 5'd16;
  localparam logic [4:0] S_AM3    = 5'd17;
  localparam logic [4:0] S_AM4    = 5'd18;
  localparam logic [4:0] S_OUT    = 5'd19;

  logic [4:0]       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             closing_q, closing_d;
  logic             m_valid_q, m_valid_d;
  logic             out_free;

  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    closing_d = closing_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.acc_op  = ACC_HOLD;
    cmd_o.step    = cnt_q;
    cmd_o.closing = closing_q;
    s_ready_o     = (state_q == S_IDLE);
    m_valid_d     = m_valid_q && !m_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          last_d  = s_last_i;
          state_d = S_LAT;
        end
      end
      S_LAT: begin
        cmd_o.mul_sel = MUL_LAT;
        state_d = S_ZINIT;
      end
      S_ZINIT: begin
        cmd_o.rot_init = 1'b1;
        cnt_d   = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot_step = 1'b1;
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(SineSteps - 1)) begin
          state_d = S_SINE;
        end
      end
      S_SINE: begin
        cmd_o.sine_load = 1'b1;
        state_d = sts_i.has_prev ? S_EMUL : S_COMMIT;
      end
      S_EMUL: begin
        cmd_o.mul_sel = MUL_DLON;
        state_d = S_ERAD;
      end
      S_ERAD: begin
        cmd_o.rad_load = 1'b1;
        state_d = S_EMLO;
      end
      S_EMLO: begin
        cmd_o.mul_sel = MUL_RAD_LO;
        state_d = S_EMHI;
      end
      S_EMHI: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_sel = MUL_RAD_HI;
        state_d = S_EACC;
      end
      S_EACC: begin
        cmd_o.acc_op = ACC_ADD32;
        state_d = S_ESUM;
      end
      S_ESUM: begin
        cmd_o.edge_add = 1'b1;
        state_d = closing_q ? S_RMUL : S_COMMIT;
      end
      S_COMMIT: begin
        if (!last_q) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end else if (sts_i.too_few) begin
          state_d = S_OUT;
        end else begin
          closing_d = 1'b1;
          state_d   = S_EMUL;
        end
      end
      S_RMUL: begin
        cmd_o.mul_sel = MUL_RSQ;
        state_d = S_RCAP;
      end
      S_RCAP: begin
        cmd_o.area_prep = 1'b1;
        state_d = S_AM0;
      end
      S_AM0: begin
        cmd_o.mul_sel = MUL_MLL;
        state_d = S_AM1;
      end
      S_AM1: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_sel = MUL_MLH;
        state_d = S_AM2;
      end
      S_AM2: begin
        cmd_o.acc_op  = ACC_ADD32;
        cmd_o.mul_sel = MUL_MHL;
        state_d = S_AM3;
      end
      S_AM3: begin
        cmd_o.acc_op  = ACC_ADD32;
        cmd_o.mul_sel = MUL_MHH;
        state_d = S_AM4;
      end
      S_AM4: begin
        cmd_o.acc_op = ACC_ADD64;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_few    = !closing_q;
          cmd_o.clear_ring = 1'b1;
          m_valid_d = 1'b1;
          closing_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      last_q    <= 1'b0;
      closing_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
      closing_q <= closing_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

// ===== src/spherical_polygon_area_unit.sv =====
// ----------------------------------------------------------------------------
// spherical_polygon_area_unit
// Ring-sum area of a spherical polygon fed one vertex per beat.
//
//   channel    dir  payload
//   s_axis     in   tdata[30:0] latitude, tdata[62:31] longitude,
//                   tlast last_vertex
//   m_axis     out  tdata[48:0] area_m2, tuser[0] too_few_vertices,
//                   tuser[1] area_saturated
//   cfg_wr     in   cfg_wr_data_i sphere_radius_m
//
// From its beat until s_axis_tready_o returns, a vertex runs the iterative
// CORDIC sine; a vertex with a preceding one also computes the edge term
// on the shared multiplier. The last vertex of a short ring then loads the
// result; that of a full ring first runs the closing edge and the four
// partial products of the area scaling.
// A result waits in the output register; only the next result stalls on it.
// Reset is asynchronous and active low; the radius returns to 6378137.
// ----------------------------------------------------------------------------
module spherical_polygon_area_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // latitude [30:0], longitude [62:31]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // area_m2 [48:0]
  output logic [1:0]  m_axis_tuser_o,  // too_few_vertices [0], area_saturated [1]
  input  logic        cfg_wr_en_i,
  input  logic [22:0] cfg_wr_data_i
);
  import spa_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [48:0] area;
  logic        few, sat;

  spa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  spa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vert_data_i   (s_axis_tdata_i[62:0]),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .area_o        (area),
    .few_o         (few),
    .sat_o         (sat)
  );

  assign m_axis_tdata_o = {7'd0, area};
  assign m_axis_tuser_o = {sat, few};

endmodule

// ===== src/spa_checker.sv =====
// ----------------------------------------------------------------------------
// spa_checker
// Port-level checks on the spherical polygon area unit, bound to the top.
// ----------------------------------------------------------------------------
module spa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_valid_i,
  input logic        s_ready_i,
  input logic        m_valid_i,
  input logic        m_ready_i,
  input logic [55:0] m_data_i,
  input logic [1:0]  m_user_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_ready_i |=> m_valid_i && $stable(m_data_i) && $stable(m_user_i))
    else $error("Output beat changed while stalled.");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_i && s_ready_i |=> !s_ready_i)
    else $error("Input ready stayed high after an accepted beat.");

  a_few_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && m_user_i[0] |-> (m_data_i == 56'd0) && !m_user_i[1])
    else $error("Short ring reported a nonzero or saturated area.");

  a_sat_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && m_user_i[1] |-> m_data_i[48:0] == {49{1'b1}})
    else $error("Saturated area is not the full-scale value.");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i |-> m_data_i[55:49] == 7'd0)
    else $error("Padding bits of the output beat are not zero.");

endmodule

bind spherical_polygon_area_unit spa_checker u_spa_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_valid_i (s_axis_tvalid_i),
  .s_ready_i (s_axis_tready_o),
  .m_valid_i (m_axis_tvalid_o),
  .m_ready_i (m_axis_tready_i),
  .m_data_i  (m_axis_tdata_o),
  .m_user_i  (m_axis_tuser_o)
);
